// ===== design/dsf_pkg.sv =====
// Package for the decimal seven-segment display frame unit.
// Request codes, frame constants, command type and segment lookup.
// No dependencies.
package dsf_pkg;

    localparam int DSF_DIGIT_POSITIONS = 7;
    localparam int DSF_BUF_BYTES       = 14;
    localparam int DSF_FRAME_LEN       = 18;
    localparam int DSF_NUM_DIGITS      = 5;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;

    localparam logic [7:0] CMD_MODE      = 8'h03;
    localparam logic [7:0] CMD_DATA      = 8'h40;
    localparam logic [7:0] CMD_ADDR      = 8'hc0;
    localparam logic [7:0] POINT_BIT     = 8'h80;
    localparam logic [7:0] CTRL_RESET    = 8'h88;
    localparam logic [16:0] VALUE_MOD    = 17'd100000;
    // floor(65536 / 10), slightly below 1/10 so the quotient never overshoots
    localparam logic [12:0] RECIP_TEN    = 13'd6553;

    typedef struct packed {
        logic [1:0]                             kind;
        logic [DSF_NUM_DIGITS-1:0][3:0]         digits;  // [0] is most significant
        logic [2:0]                             start;
        logic [2:0]                             count;   // clamped to 0..5
        logic [2:0]                             point;
    } cmd_t;

    function automatic logic [7:0] seg_lookup(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== design/dsf_if.sv =====
// Valid/ready channel interfaces for request and frame byte transactions.
// Depends on dsf_pkg.
interface dsf_req_if
    import dsf_pkg::*;
    ();
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [16:0] value;
    logic [2:0]  start_position;
    logic [2:0]  digit_count;
    logic [2:0]  point_position;

    modport source (output valid, req_type, value, start_position, digit_count,
                    point_position, input ready);
    modport sink   (input valid, req_type, value, start_position, digit_count,
                    point_position, output ready);
endinterface

interface dsf_frame_if
    import dsf_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       strobe_first;
    logic       last_byte;

    modport source (output valid, frame_byte, strobe_first, last_byte, input ready);
    modport sink   (input valid, frame_byte, strobe_first, last_byte, output ready);
endinterface

// ===== design/decimal_seven_segment_display_frame_unit.sv =====
// Seven-segment decimal display frame unit, top level.
// Instantiates dsf_front, dsf_queue and dsf_back; depends on dsf_pkg, dsf_if.
//
// Channels: request (sink) carries number writes, clears and refreshes;
// frame (source) carries frame bytes, one transaction per byte, LSB-first
// serialization is left to the link. cfg_we/cfg_wdata load the display
// control byte, sent as the last byte of every frame.
// Flow: a number write is accepted, then split into digits by one
// divide-by-ten step per cycle, then pushed to the queue; the back end
// applies it to the digit store when it pops it. A clear or refresh is
// accepted and pushed without the digit extraction.
// Refresh: a refresh occupies the back end until all 18 bytes of its frame
// have been loaded into the output register. The 2-entry command queue
// lets the front end convert the next write while a frame is being sent.
// Reset: the digit store clears to blanks, the control byte becomes 0x88,
// queue and output register empty.
// Receiver stall: the output register holds its byte and the back end
// waits; a command waiting on a full queue holds request ready low.
module decimal_seven_segment_display_frame_unit
    import dsf_pkg::*;
#(
    parameter int DIGIT_POSITIONS = DSF_DIGIT_POSITIONS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    dsf_req_if.sink     request,
    dsf_frame_if.source frame
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_valid;
    logic q_full;
    logic q_empty;
    logic q_pop;

    dsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_full  (q_full)
    );

    dsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head      (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    dsf_back #(
        .DIGIT_POSITIONS (DIGIT_POSITIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .frame     (frame)
    );

endmodule

// ===== design/dsf_front.sv =====
// Front end: accepts requests, reduces a write's value and splits it into
// decimal digits one per cycle, then hands a command to the queue.
// Depends on dsf_pkg and dsf_if.
module dsf_front
    import dsf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dsf_req_if.sink       request,
    output cmd_t          cmd,
    output logic          cmd_valid,
    input  logic          cmd_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  step_reg;
    cmd_t        cmd_reg;
    logic [16:0] val_reg;

    logic        accept;
    logic [16:0] val_mod;
    logic [29:0] prod;
    logic [13:0] quo_est;
    logic [16:0] rem_est;
    logic [13:0] quo;
    logic [3:0]  rem;

    assign request.ready = (state_reg == F_IDLE);
    assign accept        = request.valid && request.ready;
    assign cmd_valid     = (state_reg == F_PUSH);
    assign cmd           = cmd_reg;

    assign val_mod = (request.value >= VALUE_MOD) ? request.value - VALUE_MOD
                                                  : request.value;

    // divide by ten: reciprocal estimate, then one correction step
    always_comb
    begin
        prod    = 30'(val_reg) * 30'(RECIP_TEN);
        quo_est = prod[29:16];
        rem_est = val_reg - {quo_est, 3'b000} - 17'({quo_est, 1'b0});
        if (rem_est >= 17'd10)
        begin
            quo = quo_est + 14'd1;
            rem = 4'(rem_est - 17'd10);
        end
        else
        begin
            quo = quo_est;
            rem = rem_est[3:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (request.req_type == REQ_WRITE)
                        state_next = F_CONV;
                    else if (request.req_type == REQ_CLEAR ||
                             request.req_type == REQ_REFRESH)
                        state_next = F_PUSH;
                end
            end
            F_CONV:
            begin
                if (step_reg == 3'(DSF_NUM_DIGITS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!cmd_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_CONV)
                step_reg <= step_reg + 3'd1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.kind  <= request.req_type;
            cmd_reg.start <= request.start_position;
            cmd_reg.count <= (request.digit_count > 3'(DSF_NUM_DIGITS))
                             ? 3'(DSF_NUM_DIGITS) : request.digit_count;
            cmd_reg.point <= request.point_position;
            val_reg       <= val_mod;
        end
        else if (state_reg == F_CONV)
        begin
            // least significant digit first, shifted toward the high index
            cmd_reg.digits <= {cmd_reg.digits[DSF_NUM_DIGITS-2:0], rem};
            val_reg        <= 17'(quo);
        end
    end

endmodule

// ===== design/dsf_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on dsf_pkg.
module dsf_queue
    import dsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= ~rd_ptr_reg;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 2'd1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/dsf_back.sv =====
// Back end: holds the digit store and control byte, executes writes and
// clears, and sends the 18-byte frame through an output register.
// Depends on dsf_pkg and dsf_if.
module dsf_back
    import dsf_pkg::*;
#(
    parameter int DIGIT_POSITIONS = DSF_DIGIT_POSITIONS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  cmd_t        cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    dsf_frame_if.source frame
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_SEND = 1'b1;

    logic       state_reg;
    logic [4:0] cnt_reg;
    logic [7:0] ctrl_reg;
    logic [7:0] store_reg [DIGIT_POSITIONS];
    logic [7:0] store_next [DIGIT_POSITIONS];
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_strobe_reg;
    logic       out_last_reg;

    logic       slot_free;
    logic       load;
    logic [7:0] byte_next;
    logic       strobe_next;
    logic       last_next;
    logic [4:0] addr;

    logic [3:0] pos_v;
    logic [3:0] end_v;
    logic [3:0] pt_v;
    logic [2:0] idx_v;
    logic       pt_ok;

    assign slot_free    = !out_valid_reg || frame.ready;
    assign load         = (state_reg == B_SEND) && slot_free;
    assign cmd_pop      = (state_reg == B_IDLE) && !cmd_empty;
    assign frame.valid        = out_valid_reg;
    assign frame.frame_byte   = out_byte_reg;
    assign frame.strobe_first = out_strobe_reg;
    assign frame.last_byte    = out_last_reg;

    // store contents after a number write
    always_comb
    begin
        end_v = 4'(cmd.start) + 4'(cmd.count);
        pt_v  = 4'(cmd.start) + 4'(cmd.count) - 4'd1 - 4'(cmd.point);
        pt_ok = (cmd.point != 3'd0) && (cmd.point < cmd.count);
        pos_v = '0;
        idx_v = '0;
        for (int p = 0; p < DIGIT_POSITIONS; p++)
        begin
            pos_v = 4'(p);
            store_next[p] = store_reg[p];
            if (pos_v >= 4'(cmd.start) && pos_v < end_v)
            begin
                idx_v = 3'(4'(DSF_NUM_DIGITS) - 4'(cmd.count) + pos_v - 4'(cmd.start));
                store_next[p] = seg_lookup(cmd.digits[idx_v]);
            end
            if (pt_ok && pos_v == pt_v)
                store_next[p] = store_next[p] | POINT_BIT;
        end
    end

    // frame byte for the current count
    always_comb
    begin
        addr        = cnt_reg - 5'd3;
        byte_next   = '0;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        priority if (cnt_reg == 5'd0)
        begin
            byte_next   = CMD_MODE;
            strobe_next = 1'b1;
        end
        else if (cnt_reg == 5'd1)
        begin
            byte_next   = CMD_DATA;
            strobe_next = 1'b1;
        end
        else if (cnt_reg == 5'd2)
        begin
            byte_next   = CMD_ADDR;
            strobe_next = 1'b1;
        end
        else if (cnt_reg == 5'(DSF_FRAME_LEN - 1))
        begin
            byte_next   = ctrl_reg;
            strobe_next = 1'b1;
            last_next   = 1'b1;
        end
        else
        begin
            for (int p = 0; p < DIGIT_POSITIONS; p++)
            begin
                if (2 * p < DSF_BUF_BYTES && addr == 5'(2 * p))
                    byte_next = store_reg[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            ctrl_reg      <= CTRL_RESET;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < DIGIT_POSITIONS; p++)
                store_reg[p] <= '0;
        end
        else
        begin
            if (cfg_we)
                ctrl_reg <= cfg_wdata;

            if (load)
                out_valid_reg <= 1'b1;
            else if (frame.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    cnt_reg <= '0;
                    if (cmd_pop)
                    begin
                        if (cmd.kind == REQ_WRITE)
                        begin
                            for (int p = 0; p < DIGIT_POSITIONS; p++)
                                store_reg[p] <= store_next[p];
                        end
                        else if (cmd.kind == REQ_CLEAR)
                        begin
                            for (int p = 0; p < DIGIT_POSITIONS; p++)
                                store_reg[p] <= '0;
                        end
                        else if (cmd.kind == REQ_REFRESH)
                            state_reg <= B_SEND;
                    end
                end
                B_SEND:
                begin
                    if (load)
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'(DSF_FRAME_LEN - 1))
                            state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= byte_next;
            out_strobe_reg <= strobe_next;
            out_last_reg   <= last_next;
        end
    end

endmodule
